@@ design/hidk_pkg.sv @@
// Package for the HID keyboard report translator.
// Holds the event kinds, modifier and usage constants, the set-1 scancode table and the
// ASCII tables. No dependencies.
`timescale 1ns / 1ps

package hidk_pkg;

	localparam int MOD_W = 8;
	localparam int KEY_W = 8;
	localparam int MOD_EVENTS = 6;
	localparam int SCAN_LEN = 84;
	localparam int ASCII_LEN = 57;
	localparam int ASCII_FIRST = 4;

	localparam logic [1:0] KIND_SCAN = 2'd0;
	localparam logic [1:0] KIND_CHAR = 2'd1;
	localparam logic [1:0] KIND_CTRLC = 2'd2;

	localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;
	localparam logic [7:0] MOD_CTRL_MASK = 8'h11;
	localparam logic [7:0] USAGE_C = 8'h06;
	localparam logic [7:0] CTRL_C_CHAR = 8'h03;

	localparam logic [7:0] MOD_MASK [0:MOD_EVENTS-1] = '{8'h01, 8'h02, 8'h04, 8'h10, 8'h20, 8'h40};
	localparam logic [7:0] MOD_SCAN [0:MOD_EVENTS-1] = '{8'h1D, 8'h2A, 8'h38, 8'h1D, 8'h36, 8'h38};

	localparam logic [7:0] SCAN_ROM [0:SCAN_LEN-1] = '{
		8'h00, 8'h00, 8'h00, 8'h00,
		8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23,
		8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19,
		8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D,
		8'h15, 8'h2C,
		8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
		8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39,
		8'h0C, 8'h0D, 8'h1A, 8'h1B, 8'h2B, 8'h2B, 8'h27, 8'h28,
		8'h29, 8'h33, 8'h34, 8'h35,
		8'h3A,
		8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58,
		8'h00, 8'h46, 8'h00,
		8'hD2, 8'hC7, 8'hC9, 8'hD3, 8'hCF, 8'hD1, 8'hCD, 8'hCB, 8'hD0, 8'hC8,
		8'h45
	};

	localparam logic [7:0] PLAIN_ROM [0:ASCII_LEN-1] = '{
		8'h00, 8'h00, 8'h00, 8'h00,
		"a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k", "l",
		"m", "n", "o", "p", "q", "r", "s", "t", "u", "v", "w", "x", "y", "z",
		"1", "2", "3", "4", "5", "6", "7", "8", "9", "0",
		8'h0A, 8'h00, 8'h08, 8'h09, 8'h20,
		"-", "=", "[", "]", 8'h5C, 8'h00, ";", 8'h27, 8'h60, ",", ".", "/"
	};

	localparam logic [7:0] SHIFT_ROM [0:ASCII_LEN-1] = '{
		8'h00, 8'h00, 8'h00, 8'h00,
		"A", "B", "C", "D", "E", "F", "G", "H", "I", "J", "K", "L",
		"M", "N", "O", "P", "Q", "R", "S", "T", "U", "V", "W", "X", "Y", "Z",
		"!", "@", "#", "$", "%", "^", "&", "*", "(", ")",
		8'h0A, 8'h00, 8'h08, 8'h09, 8'h20,
		"_", "+", "{", "}", "|", 8'h00, ":", 8'h22, "~", "<", ">", "?"
	};

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] code;
		logic down;
	} evt_t;

	function automatic int job_width(input int slots);
		return 2 * MOD_W + slots * (2 * KEY_W + 2);
	endfunction

	function automatic logic [7:0] scan_of(input logic [7:0] code);
		logic [7:0] res;
		res = 8'h00;
		if (code < 8'(SCAN_LEN)) begin
			res = SCAN_ROM[code[6:0]];
		end
		return res;
	endfunction

	function automatic logic [7:0] ascii_of(input logic [7:0] code, input logic shift);
		logic [7:0] res;
		res = 8'h00;
		if (code >= 8'(ASCII_FIRST) && code < 8'(ASCII_LEN)) begin
			res = shift ? SHIFT_ROM[code[5:0]] : PLAIN_ROM[code[5:0]];
		end
		return res;
	endfunction

endpackage

@@ design/hidk_if.sv @@
// Handshake interfaces for the report input channel and the event output channel.
// No dependencies.
`timescale 1ns / 1ps

interface hidk_report_if #(parameter int KEY_SLOTS = 6) ();
	logic valid;
	logic ready;
	logic [7:0] modifier_bits;
	logic [KEY_SLOTS*8-1:0] key_slot;
	logic report_too_short;

	modport source(output valid, modifier_bits, key_slot, report_too_short, input ready);
	modport sink(input valid, modifier_bits, key_slot, report_too_short, output ready);
endinterface

interface hidk_event_if ();
	logic valid;
	logic ready;
	logic [1:0] event_kind;
	logic [7:0] code_value;
	logic key_down;
	logic last_of_run;

	modport source(output valid, event_kind, code_value, key_down, last_of_run, input ready);
	modport sink(input valid, event_kind, code_value, key_down, last_of_run, output ready);
endinterface

@@ design/hidk_front.sv @@
// Front end: accepts reports, compares them with the stored previous report and
// builds a job with new-key and released-key flags. Depends on hidk_pkg and hidk_if.
`timescale 1ns / 1ps

module hidk_front import hidk_pkg::*; #(
	parameter int KEY_SLOTS = 6,
	parameter int JOB_W = 124
) (
	input  logic clk,
	input  logic arst_n,
	hidk_report_if.sink rpt,
	output logic job_valid,
	input  logic job_ready,
	output logic [JOB_W-1:0] job_data
);

	logic [MOD_W-1:0] prev_mods_q;
	logic [KEY_SLOTS*KEY_W-1:0] prev_keys_q;
	logic [KEY_SLOTS-1:0] new_flag;
	logic [KEY_SLOTS-1:0] rel_flag;
	logic take;

	assign rpt.ready = job_ready;
	assign job_valid = rpt.valid && !rpt.report_too_short;
	assign take = rpt.valid && job_ready && !rpt.report_too_short;

	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			logic held;
			logic still;
			held = 1'b0;
			still = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (prev_keys_q[j*KEY_W +: KEY_W] == rpt.key_slot[i*KEY_W +: KEY_W]) begin
					held = 1'b1;
				end
				if (rpt.key_slot[j*KEY_W +: KEY_W] == prev_keys_q[i*KEY_W +: KEY_W]) begin
					still = 1'b1;
				end
			end
			new_flag[i] = (rpt.key_slot[i*KEY_W +: KEY_W] != '0) && !held;
			rel_flag[i] = (prev_keys_q[i*KEY_W +: KEY_W] != '0) && !still;
		end
	end

	assign job_data = {rel_flag, prev_keys_q, new_flag, rpt.key_slot, prev_mods_q,
		rpt.modifier_bits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mods_q <= '0;
			prev_keys_q <= '0;
		end else if (take) begin
			prev_mods_q <= rpt.modifier_bits;
			prev_keys_q <= rpt.key_slot;
		end
	end

endmodule

@@ design/hidk_queue.sv @@
// Two-entry job queue between the front end and the event sequencer.
// Depends on nothing but its width parameter.
`timescale 1ns / 1ps

module hidk_queue #(
	parameter int WIDTH = 124
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic out_valid,
	input  logic out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int DEPTH = 2;

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	logic pop;

	assign in_ready = count_q != 2'(DEPTH);
	assign out_valid = count_q != 2'd0;
	assign out_data = mem_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(DEPTH))
		else $error("queue count beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with count");
`endif

endmodule

@@ design/hidk_back.sv @@
// Event sequencer: takes one job at a time from the queue and sends its events one per
// cycle while the output is not stalled, through an output register. Depends on hidk_pkg and hidk_if.
`timescale 1ns / 1ps

module hidk_back import hidk_pkg::*; #(
	parameter int KEY_SLOTS = 6,
	parameter int JOB_W = 124
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  logic [JOB_W-1:0] job_data,
	hidk_event_if.source evt
);

	localparam int NSTEP = MOD_EVENTS + 3 * KEY_SLOTS;
	localparam int OFF_KEYS = 2 * MOD_W;
	localparam int OFF_NEW = OFF_KEYS + KEY_SLOTS * KEY_W;
	localparam int OFF_PREV = OFF_NEW + KEY_SLOTS;
	localparam int OFF_REL = OFF_PREV + KEY_SLOTS * KEY_W;

	logic [JOB_W-1:0] job_q;
	logic busy_q;
	logic [NSTEP-1:0] done_q;
	logic out_valid_q;
	evt_t out_evt_q;
	logic out_last_q;

	logic [MOD_W-1:0] mods;
	logic [MOD_W-1:0] prev_mods;
	logic shift;
	logic ctrl;
	logic [NSTEP-1:0] step_valid;
	evt_t step_evt [NSTEP];
	logic [NSTEP-1:0] pending;
	logic [NSTEP-1:0] pick;
	evt_t sel_evt;
	logic adv;
	logic job_pop;
	logic emit;
	logic final_one;

	assign mods = job_q[0 +: MOD_W];
	assign prev_mods = job_q[MOD_W +: MOD_W];
	assign shift = |(mods & MOD_SHIFT_MASK);
	assign ctrl = |(mods & MOD_CTRL_MASK);

	always_comb begin
		for (int m = 0; m < MOD_EVENTS; m++) begin
			logic now;
			now = |(mods & MOD_MASK[m]);
			step_valid[m] = now != (|(prev_mods & MOD_MASK[m]));
			step_evt[m] = '{kind: KIND_SCAN, code: MOD_SCAN[m], down: now};
		end
		for (int i = 0; i < KEY_SLOTS; i++) begin
			logic [7:0] key;
			logic [7:0] pkey;
			logic is_cc;
			logic [7:0] sc;
			logic [7:0] ch;
			key = job_q[OFF_KEYS + i*KEY_W +: KEY_W];
			pkey = job_q[OFF_PREV + i*KEY_W +: KEY_W];
			is_cc = ctrl && (key == USAGE_C);
			sc = scan_of(key);
			ch = ascii_of(key, shift);
			step_valid[MOD_EVENTS + 2*i] = job_q[OFF_NEW + i] && (is_cc || sc != 8'h00);
			step_evt[MOD_EVENTS + 2*i] = is_cc ?
				evt_t'{kind: KIND_CTRLC, code: CTRL_C_CHAR, down: 1'b1} :
				evt_t'{kind: KIND_SCAN, code: sc, down: 1'b1};
			step_valid[MOD_EVENTS + 2*i + 1] = job_q[OFF_NEW + i] && !is_cc && ch != 8'h00;
			step_evt[MOD_EVENTS + 2*i + 1] = '{kind: KIND_CHAR, code: ch, down: 1'b1};
			step_valid[MOD_EVENTS + 2*KEY_SLOTS + i] = job_q[OFF_REL + i] &&
				scan_of(pkey) != 8'h00;
			step_evt[MOD_EVENTS + 2*KEY_SLOTS + i] =
				'{kind: KIND_SCAN, code: scan_of(pkey), down: 1'b0};
		end
	end

	assign pending = busy_q ? (step_valid & ~done_q) : '0;
	assign pick = pending & (~pending + NSTEP'(1));
	assign final_one = (pending & ~pick) == '0;

	always_comb begin
		sel_evt = '0;
		for (int s = 0; s < NSTEP; s++) begin
			if (pick[s]) begin
				sel_evt = sel_evt | step_evt[s];
			end
		end
	end

	assign adv = !out_valid_q || evt.ready;
	assign job_ready = !busy_q;
	assign job_pop = job_valid && !busy_q;
	assign emit = adv && (pending != '0);

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job_data;
		end
		if (emit) begin
			out_evt_q <= sel_evt;
			out_last_q <= final_one;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= emit;
			end
			if (job_pop) begin
				busy_q <= 1'b1;
				done_q <= '0;
			end else if (busy_q && adv) begin
				done_q <= done_q | pick;
				if (final_one) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign evt.valid = out_valid_q;
	assign evt.event_kind = out_evt_q.kind;
	assign evt.code_value = out_evt_q.code;
	assign evt.key_down = out_evt_q.down;
	assign evt.last_of_run = out_last_q;

`ifndef SYNTHESIS
	a_done_subset: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ((done_q & ~step_valid) == '0))
		else $error("completed step that was never valid");
	a_scan_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_evt_q.kind == KIND_SCAN) |-> (out_evt_q.code != 8'h00))
		else $error("scancode event with zero code");
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && final_one) |=> !busy_q)
		else $error("sequencer still busy after final event");
	a_char_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_evt_q.kind != KIND_SCAN) |-> out_evt_q.down)
		else $error("character event marked as release");
`endif

endmodule

@@ design/hid_keyboard_report_to_scancodes.sv @@
// Boot-keyboard report to set-1 scancode and ASCII event translator.
// A report is stored in the queue and then in the sequencer's job register; its events leave
// through the output register, one per cycle while the output is not stalled. A report with
// no events still passes through the sequencer; a short report is taken but builds no job.
// A two-entry job queue lets reports be taken while events are still being sent.
// Reset (arst_n, asynchronous, active low) clears the stored modifiers and keys to zero.
`timescale 1ns / 1ps

module hid_keyboard_report_to_scancodes import hidk_pkg::*; #(
	parameter int KEY_SLOTS = 6
) (
	input  logic clk,
	input  logic arst_n,
	hidk_report_if.sink rpt,
	hidk_event_if.source evt
);

	localparam int JOB_W = job_width(KEY_SLOTS);

	logic fq_valid;
	logic fq_ready;
	logic [JOB_W-1:0] fq_data;
	logic qb_valid;
	logic qb_ready;
	logic [JOB_W-1:0] qb_data;

	hidk_front #(
		.KEY_SLOTS(KEY_SLOTS),
		.JOB_W(JOB_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.rpt(rpt),
		.job_valid(fq_valid),
		.job_ready(fq_ready),
		.job_data(fq_data)
	);

	hidk_queue #(
		.WIDTH(JOB_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fq_valid),
		.in_ready(fq_ready),
		.in_data(fq_data),
		.out_valid(qb_valid),
		.out_ready(qb_ready),
		.out_data(qb_data)
	);

	hidk_back #(
		.KEY_SLOTS(KEY_SLOTS),
		.JOB_W(JOB_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(qb_valid),
		.job_ready(qb_ready),
		.job_data(qb_data),
		.evt(evt)
	);

endmodule
